// File: design/periodic_task_dispatcher_macros.svh
// ----------------------------------------------------------------------------
// periodic_task_dispatcher assertion macros
// Same-cycle and next-cycle implication checks on clk, gated by reset.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_DISPATCHER_MACROS_SVH
`define PERIODIC_TASK_DISPATCHER_MACROS_SVH

// same-cycle implication
`define PTD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg
// Types, constants and defaults shared by the periodic task dispatcher.
// ----------------------------------------------------------------------------
package ptd_pkg;

  localparam int NUM_TASKS_DEF       = 4;
  localparam int NUM_PRIO_LEVELS_DEF = 4;
  localparam int PERIOD_WIDTH_DEF    = 16;

  localparam int TASK_IDX_W  = 2;
  localparam int PRIO_W      = 2;
  localparam int PERIOD_SLOT = 16;
  localparam int MASK_W      = 4;
  localparam int PRIO_TBL_W  = 8;
  localparam int PERIOD_TBL_W = 64;
  localparam int CFG_IDX_W   = 2;

  localparam logic [MASK_W-1:0] PERIODIC_MASK_RST = 4'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_PERIODIC_MASK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIORITY_TABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_TABLE   = 2'd2;

  localparam logic CMD_TICK        = 1'b0;
  localparam logic CMD_SET_PENDING = 1'b1;

  typedef struct packed {
    logic                  cmd;
    logic [TASK_IDX_W-1:0] task_index;
  } ptd_in_t;

  typedef struct packed {
    logic [TASK_IDX_W-1:0] dispatched_task;
    logic                  dispatch_valid;
    logic                  last;
  } ptd_out_t;

  typedef enum logic {
    ST_IDLE,
    ST_DISP
  } ptd_state_t;

  // controller -> datapath
  typedef struct packed {
    logic tick;
    logic set_pend;
    logic pop;
  } ptd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;
  } ptd_stat_t;

endpackage

// File: design/ptd_ctrl.sv
// ----------------------------------------------------------------------------
// ptd_ctrl
// Sequencer: accepts beats while idle, then pops one dispatch per free
// output slot until the last one of the tick.
// ----------------------------------------------------------------------------
module ptd_ctrl
  import ptd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_cmd,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output ptd_cmd_t  cmd,
  input  ptd_stat_t stat
);

  ptd_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    out_free      = !out_valid_r || !out_stall;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    in_stall      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_cmd == CMD_TICK) begin
            cmd.tick  = 1'b1;
            state_nxt = ST_DISP;
          end else begin
            cmd.set_pend = 1'b1;
          end
        end
      end
      ST_DISP: begin
        if (out_free) begin
          cmd.pop       = 1'b1;
          out_valid_nxt = 1'b1;
          if (stat.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// File: design/ptd_dpath.sv
// ----------------------------------------------------------------------------
// ptd_dpath
// Config registers, countdowns, pending marks, dispatch pick and the
// result register.
// ----------------------------------------------------------------------------
module ptd_dpath
  import ptd_pkg::*;
#(
  parameter int NUM_TASKS       = NUM_TASKS_DEF,
  parameter int NUM_PRIO_LEVELS = NUM_PRIO_LEVELS_DEF,
  parameter int PERIOD_WIDTH    = PERIOD_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [PERIOD_TBL_W-1:0] cfg_data,
  input  logic [TASK_IDX_W-1:0]   task_index,
  input  ptd_cmd_t                cmd,
  output ptd_stat_t               stat,
  output ptd_out_t                out_data
);

  logic [MASK_W-1:0]       mask_r;
  logic [PRIO_TBL_W-1:0]   prio_r;
  logic [PERIOD_TBL_W-1:0] period_r;

  logic [PERIOD_WIDTH-1:0] cd_r   [NUM_TASKS];
  logic [PERIOD_WIDTH-1:0] cd_nxt [NUM_TASKS];
  logic [NUM_TASKS-1:0]    pend_r, pend_nxt;
  logic [NUM_TASKS-1:0]    elig;
  logic [TASK_IDX_W-1:0]   sel;
  logic                    found;
  logic [2:0]              elig_cnt;
  logic [PERIOD_WIDTH-1:0] per;
  ptd_out_t                out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r   <= PERIODIC_MASK_RST;
      prio_r   <= '0;
      period_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PERIODIC_MASK:  mask_r   <= cfg_data[MASK_W-1:0];
        CFG_PRIORITY_TABLE: prio_r   <= cfg_data[PRIO_TBL_W-1:0];
        CFG_PERIOD_TABLE:   period_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // pick: lowest level first, then lowest index
  always_comb begin
    sel      = '0;
    found    = 1'b0;
    elig_cnt = '0;
    for (int t = 0; t < NUM_TASKS; t++) begin
      elig[t] = pend_r[t] && (int'(prio_r[PRIO_W*t +: PRIO_W]) < NUM_PRIO_LEVELS);
      if (elig[t]) begin
        elig_cnt = elig_cnt + 3'd1;
      end
    end
    for (int l = 0; l < NUM_PRIO_LEVELS; l++) begin
      for (int t = 0; t < NUM_TASKS; t++) begin
        if (!found && elig[t] && int'(prio_r[PRIO_W*t +: PRIO_W]) == l) begin
          found = 1'b1;
          sel   = TASK_IDX_W'(t);
        end
      end
    end
  end

  assign stat.last = (elig_cnt <= 3'd1);

  always_comb begin
    pend_nxt = pend_r;
    per      = '0;
    for (int t = 0; t < NUM_TASKS; t++) begin
      cd_nxt[t] = cd_r[t];
    end
    if (cmd.set_pend) begin
      for (int t = 0; t < NUM_TASKS; t++) begin
        if (int'(task_index) == t) begin
          pend_nxt[t] = 1'b1;
        end
      end
    end
    if (cmd.tick) begin
      for (int t = 0; t < NUM_TASKS; t++) begin
        per = period_r[PERIOD_SLOT*t +: PERIOD_WIDTH];
        if (mask_r[t]) begin
          if (per != '0 && cd_r[t] != '0) begin
            cd_nxt[t] = cd_r[t] - PERIOD_WIDTH'(1);
          end else begin
            cd_nxt[t]   = per;
            pend_nxt[t] = 1'b1;
          end
        end
      end
    end
    if (cmd.pop && found) begin
      for (int t = 0; t < NUM_TASKS; t++) begin
        if (int'(sel) == t) begin
          pend_nxt[t] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      for (int t = 0; t < NUM_TASKS; t++) begin
        cd_r[t] <= '0;
      end
    end else begin
      pend_r <= pend_nxt;
      for (int t = 0; t < NUM_TASKS; t++) begin
        cd_r[t] <= cd_nxt[t];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      out_data_r.dispatched_task <= sel;
      out_data_r.dispatch_valid  <= found;
      out_data_r.last            <= (elig_cnt <= 3'd1);
    end
  end

  assign out_data = out_data_r;

endmodule

// File: design/periodic_task_dispatcher.sv
// ----------------------------------------------------------------------------
// periodic_task_dispatcher
// Tick-driven scheduler: periodic countdowns, pending marks, and dispatch in
// priority order, one result beat per cycle while out_stall is low.
//
//   channel  dir  handshake           beat
//   in_      in   in_valid/in_stall   ptd_in_t  {cmd, task_index}
//   out_     out  out_valid/out_stall ptd_out_t {dispatched_task, dispatch_valid, last}
//   cfg_     in   cfg_valid/cfg_ready cfg_index, cfg_data (64 bits)
//
// A set-pending beat marks its task pending. A tick updates the countdowns,
// then the dispatch sequencer pops one task per cycle while the output is
// free, giving 1 to NUM_TASKS results. New input is held off until the
// tick's last result is in the output register. Reset is synchronous;
// out_stall holds the result register and pauses the sequencer.
// ----------------------------------------------------------------------------
module periodic_task_dispatcher
  import ptd_pkg::*;
#(
  parameter int NUM_TASKS       = NUM_TASKS_DEF,
  parameter int NUM_PRIO_LEVELS = NUM_PRIO_LEVELS_DEF,
  parameter int PERIOD_WIDTH    = PERIOD_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  ptd_in_t                 in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output ptd_out_t                out_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [PERIOD_TBL_W-1:0] cfg_data
);

`include "periodic_task_dispatcher_macros.svh"

  ptd_cmd_t  cmd;
  ptd_stat_t stat;

  assign cfg_ready = 1'b1;

  ptd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_data.cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  ptd_dpath #(
    .NUM_TASKS       (NUM_TASKS),
    .NUM_PRIO_LEVELS (NUM_PRIO_LEVELS),
    .PERIOD_WIDTH    (PERIOD_WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .task_index (in_data.task_index),
    .cmd        (cmd),
    .stat       (stat),
    .out_data   (out_data)
  );

  `PTD_ASSERT_NOW(a_empty_is_last, out_valid && !out_data.dispatch_valid,
    out_data.last, "empty tick result must be last")
  `PTD_ASSERT_NEXT(a_tick_busy, in_valid && !in_stall && in_data.cmd == CMD_TICK,
    in_stall, "tick must hold off input")
  `PTD_ASSERT_NEXT(a_more_follows, out_valid && !out_stall && !out_data.last,
    out_valid, "non-last beat must be followed")

endmodule
